// ----- rtl/sfd_pkg.sv -----
// Shared constants, types and arithmetic helpers for the stereo feedback delay.
package sfd_pkg;

  localparam int DEPTH   = 131072;
  localparam int SMP_W   = 16;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int DLY_W   = 17;
  localparam int FB_W    = 15;
  localparam int MIX_W   = 16;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int Q_FRAC  = 15;
  localparam int UNITY   = 1 << Q_FRAC;
  localparam int RND     = 1 << (Q_FRAC - 1);
  localparam int FBP_W   = SMP_W + FB_W + 2;
  localparam int MXP_W   = SMP_W + MIX_W + 3;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIX   = 2'd2;

  localparam logic signed [63:0] SMP_MAX = (64'sd1 <<< (SMP_W - 1)) - 64'sd1;
  localparam logic signed [63:0] SMP_MIN = -SMP_MAX - 64'sd1;

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic [ADDR_W-1:0]       addr_t;

  typedef struct packed {
    logic acc;   // input beat taken, stage 1 loads
    logic ld2;   // stage 2 loads
    logic ld3;   // stage 3 loads
    logic we;    // stage 1 item writes its store entry
  } pipe_ctl_t;

  typedef struct packed {
    addr_t wr;
    logic  fwd;   // read hits the entry written as this item entered
    logic  rdv;   // entry was written since reset
    logic  zero;  // zero delay: output sees the fresh entry
  } s1_t;

  typedef struct packed {
    logic [FB_W-1:0]  fb;
    logic [MIX_W-1:0] mix;
  } gain_t;

  function automatic smp_t sat(input logic signed [63:0] v);
    if (v > SMP_MAX) return SMP_W'(SMP_MAX);
    if (v < SMP_MIN) return SMP_W'(SMP_MIN);
    return SMP_W'(v);
  endfunction

  // Reduce a delay modulo DEPTH by restoring subtraction; stages that
  // cannot fire fold away at elaboration.
  function automatic addr_t dly_mod(input logic [DLY_W-1:0] v);
    logic [63:0] r;
    r = 64'(v);
    for (int k = DLY_W; k >= 0; k--) begin
      if (r >= (64'(DEPTH) << k)) r = r - (64'(DEPTH) << k);
    end
    return ADDR_W'(r);
  endfunction

endpackage

// ----- rtl/sfd_ram.sv -----
// Generic simple dual-port RAM with registered read.
module sfd_ram #(
  parameter int DATA_W = 16,
  parameter int WORDS  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sfd_ctrl.sv -----
// Shared pointer, fill tracking, configuration and pipeline valid chain.
module sfd_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic                           out_free,
  input  logic                           cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [sfd_pkg::CFG_W-1:0]      cfg_wdata,
  output sfd_pkg::pipe_ctl_t             ctl,
  output sfd_pkg::s1_t                   s1,
  output sfd_pkg::addr_t                 rd_addr,
  output sfd_pkg::gain_t                 gain,
  output logic                           v3
);

  logic v1_r, v2_r, v3_r;
  logic free1, free2, free3;
  sfd_pkg::addr_t wp_r, dl_r;
  logic [sfd_pkg::FILL_W-1:0] fill_r;
  logic [sfd_pkg::FB_W-1:0]   fb_r;
  logic [sfd_pkg::MIX_W-1:0]  mix_r;
  sfd_pkg::s1_t s1_r;
  logic [sfd_pkg::ADDR_W:0] diff, wrapped;
  logic [sfd_pkg::MIX_W-1:0] mix_wr;

  assign free3 = !v3_r || out_free;
  assign free2 = !v2_r || free3;
  assign free1 = !v1_r || free2;
  assign in_tready = free1;

  assign ctl.acc = in_tvalid && free1;
  assign ctl.ld2 = free2;
  assign ctl.ld3 = free3;
  assign ctl.we  = v1_r && free2;

  assign s1   = s1_r;
  assign v3   = v3_r;
  assign gain = '{fb: fb_r, mix: mix_r};

  // read position = write pointer minus delay, wrapped into the store
  assign diff    = {1'b0, wp_r} - {1'b0, dl_r};
  assign wrapped = diff + (sfd_pkg::ADDR_W + 1)'(sfd_pkg::DEPTH);
  assign rd_addr = diff[sfd_pkg::ADDR_W] ? wrapped[sfd_pkg::ADDR_W-1:0]
                                         : diff[sfd_pkg::ADDR_W-1:0];

  assign mix_wr = cfg_wdata[sfd_pkg::MIX_W-1:0] > sfd_pkg::MIX_W'(sfd_pkg::UNITY)
                ? sfd_pkg::MIX_W'(sfd_pkg::UNITY) : cfg_wdata[sfd_pkg::MIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      wp_r   <= '0;
      fill_r <= '0;
      dl_r   <= '0;
      fb_r   <= '0;
      mix_r  <= '0;
    end else begin
      if (free1) v1_r <= in_tvalid;
      if (free2) v2_r <= v1_r;
      if (free3) v3_r <= v2_r;
      if (ctl.acc) begin
        wp_r <= (wp_r == sfd_pkg::ADDR_W'(sfd_pkg::DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      // writes land in pointer order, so entries below the count hold data
      if (ctl.we && fill_r != sfd_pkg::FILL_W'(sfd_pkg::DEPTH)) fill_r <= fill_r + 1'b1;
      if (cfg_we) begin
        unique case (cfg_addr)
          sfd_pkg::REG_DELAY: dl_r  <= sfd_pkg::dly_mod(cfg_wdata[sfd_pkg::DLY_W-1:0]);
          sfd_pkg::REG_FB:    fb_r  <= cfg_wdata[sfd_pkg::FB_W-1:0];
          sfd_pkg::REG_MIX:   mix_r <= mix_wr;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      s1_r.wr   <= wp_r;
      s1_r.fwd  <= v1_r && (s1_r.wr == rd_addr);
      s1_r.rdv  <= sfd_pkg::FILL_W'(rd_addr) < fill_r;
      s1_r.zero <= (dl_r == '0);
    end
  end

endmodule

// ----- rtl/sfd_lane.sv -----
// One channel: delay store, feedback update and wet/dry mix pipeline.
module sfd_lane (
  input  logic               clk,
  input  sfd_pkg::pipe_ctl_t ctl,
  input  sfd_pkg::s1_t       s1,
  input  sfd_pkg::addr_t     rd_addr,
  input  sfd_pkg::gain_t     gain,
  input  sfd_pkg::smp_t      smp_in,
  output sfd_pkg::smp_t      res
);

  sfd_pkg::smp_t in1_r, fwdd1_r, in2_r, dp2_r;
  sfd_pkg::smp_t ram_q, d, stored, dp;
  logic signed [sfd_pkg::FBP_W-1:0] pfb, rfb;
  logic signed [sfd_pkg::MXP_W-1:0] pd, pw, pd3_r, pw3_r, acc, rmx;
  logic [sfd_pkg::MIX_W:0] dry;

  sfd_ram #(.DATA_W(sfd_pkg::SMP_W), .WORDS(sfd_pkg::DEPTH)) u_store (
    .clk   (clk),
    .we    (ctl.we),
    .waddr (s1.wr),
    .wdata (stored),
    .re    (ctl.acc),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // stage 1: delayed value and feedback write
  always_comb begin
    if (s1.fwd)      d = fwdd1_r;
    else if (s1.rdv) d = ram_q;
    else             d = '0;
    pfb = sfd_pkg::FBP_W'(d) * sfd_pkg::FBP_W'(signed'({1'b0, gain.fb}));
    rfb = (pfb + sfd_pkg::FBP_W'(sfd_pkg::RND)) >>> sfd_pkg::Q_FRAC;
    stored = sfd_pkg::sat(64'(in1_r) + 64'(rfb));
    dp = s1.zero ? stored : d;
  end

  // stage 2: mix products
  always_comb begin
    dry = (sfd_pkg::MIX_W + 1)'(sfd_pkg::UNITY) - {1'b0, gain.mix};
    pd  = sfd_pkg::MXP_W'(in2_r) * sfd_pkg::MXP_W'(signed'({1'b0, dry}));
    pw  = sfd_pkg::MXP_W'(dp2_r) * sfd_pkg::MXP_W'(signed'({1'b0, gain.mix}));
  end

  // stage 3: sum, round, saturate
  always_comb begin
    acc = pd3_r + pw3_r;
    rmx = (acc + sfd_pkg::MXP_W'(sfd_pkg::RND)) >>> sfd_pkg::Q_FRAC;
    res = sfd_pkg::sat(64'(rmx));
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      in1_r   <= smp_in;
      fwdd1_r <= stored;  // value written as this beat enters
    end
    if (ctl.ld2) begin
      in2_r <= in1_r;
      dp2_r <= dp;
    end
    if (ctl.ld3) begin
      pd3_r <= pd;
      pw3_r <= pw;
    end
  end

endmodule

// ----- rtl/stereo_feedback_delay.sv -----
// Top level: stereo feedback comb delay with two channel lanes and output merge.
//
// Channel   Dir  tdata / data bits                    Notes
// in_*      in   [15:0] left_in, [31:16] right_in     one stereo frame per beat
// out_*     out  [15:0] left_out, [31:16] right_out   one result per input beat
// cfg_*     in   index 0 delay, 1 feedback, 2 mix     write only, take effect at once
//
// One frame per cycle while out_tready does not stall; results pass stage 1, 2, 3 and output registers.
// The store read port and the forward register from the write stage set that rate.
// No clearing pass: a fill count marks entries not yet written since reset as zero.
// Each stage holds while the next one is full; the output register holds under stall.
module stereo_feedback_delay (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [15:0] left_in, [31:16] right_in
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // [15:0] left_out, [31:16] right_out
  input  logic                          cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [sfd_pkg::CFG_W-1:0]     cfg_wdata
);

  sfd_pkg::pipe_ctl_t ctl;
  sfd_pkg::s1_t       s1;
  sfd_pkg::addr_t     rd_addr;
  sfd_pkg::gain_t     gain;
  sfd_pkg::smp_t      res_l, res_r;
  logic               v3, out_free, vout_r;
  logic [31:0]        out_r;

  assign out_free   = !vout_r || out_tready;
  assign out_tvalid = vout_r;
  assign out_tdata  = out_r;

  sfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_free  (out_free),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .s1        (s1),
    .rd_addr   (rd_addr),
    .gain      (gain),
    .v3        (v3)
  );

  sfd_lane u_lane_l (
    .clk     (clk),
    .ctl     (ctl),
    .s1      (s1),
    .rd_addr (rd_addr),
    .gain    (gain),
    .smp_in  (in_tdata[15:0]),
    .res     (res_l)
  );

  sfd_lane u_lane_r (
    .clk     (clk),
    .ctl     (ctl),
    .s1      (s1),
    .rd_addr (rd_addr),
    .gain    (gain),
    .smp_in  (in_tdata[31:16]),
    .res     (res_r)
  );

  // merge both lanes into the output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (out_free) begin
      vout_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) out_r <= {res_r, res_l};
  end

endmodule
